@@ rtl/isqrt_pkg.sv @@
// Shared constants and controller/datapath interface types for the integer square root.
`default_nettype none
package isqrt_pkg;

	localparam int DEF_RADICAND_WIDTH = 32;
	localparam int RADICAND_PORT_W = 32;
	localparam int ROOT_W = 16;

	typedef struct packed {
		logic load;
		logic step;
		logic capture;
	} isqrt_cmd_t;

	typedef struct packed {
		logic last;
	} isqrt_sts_t;

endpackage
`default_nettype wire

@@ rtl/integer_square_root.sv @@
// Top level of the integer square root: floor root of one unsigned radicand per beat.
//
//   Channel | Signals                       | Direction
//   input   | in_valid, in_stall, radicand  | radicand in, one beat per item
//   output  | out_valid, out_stall, root    | root out, one beat per item
//
// An item begins with a load, then yields one root bit per cycle from the
// shared compare-and-subtract step until the last root bit is done.
// The output register frees the datapath, so a new radicand is taken while a
// root waits; a finished root waits in the datapath only while the previous
// root is still held, and the input stalls until the finished root is captured.
// Reset clears the state machine and the output valid flag.
`default_nettype none
module integer_square_root #(
	parameter int RADICAND_WIDTH = isqrt_pkg::DEF_RADICAND_WIDTH
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic [isqrt_pkg::RADICAND_PORT_W-1:0]  radicand,
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic [isqrt_pkg::ROOT_W-1:0]                root
);
	import isqrt_pkg::*;

	isqrt_cmd_t cmd;
	isqrt_sts_t sts;

	isqrt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	isqrt_datapath #(
		.RADICAND_WIDTH (RADICAND_WIDTH)
	) u_datapath (
		.clk      (clk),
		.cmd      (cmd),
		.radicand (radicand),
		.sts      (sts),
		.root     (root)
	);

endmodule
`default_nettype wire

@@ rtl/isqrt_datapath.sv @@
// Datapath of the integer square root: digit-by-digit remainder, root and output registers.
`default_nettype none
module isqrt_datapath #(
	parameter int RADICAND_WIDTH = isqrt_pkg::DEF_RADICAND_WIDTH
) (
	input  wire logic                                   clk,
	input  wire isqrt_pkg::isqrt_cmd_t                  cmd,
	input  wire logic [isqrt_pkg::RADICAND_PORT_W-1:0]  radicand,
	output isqrt_pkg::isqrt_sts_t                       sts,
	output logic [isqrt_pkg::ROOT_W-1:0]                root
);
	import isqrt_pkg::*;

	localparam int RW2 = RADICAND_WIDTH + (RADICAND_WIDTH % 2);
	localparam int RTW = RW2 / 2;
	localparam int CNT_W = (RTW > 1) ? $clog2(RTW) : 1;

	logic [RW2-1:0]   x_q;
	logic [RTW:0]     rem_q;
	logic [RTW-1:0]   res_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ROOT_W-1:0] root_q;

	logic [63:0]               radicand_ext;
	logic [RADICAND_WIDTH-1:0] radicand_used;
	logic [RTW+2:0]            rem_sh;
	logic [RTW+2:0]            trial;
	logic [RTW+2:0]            diff;
	logic                      ge;
	logic [RTW-1:0]            res_next;

	always_comb begin
		radicand_ext  = 64'(radicand);
		radicand_used = radicand_ext[RADICAND_WIDTH-1:0];
		rem_sh        = {rem_q, x_q[RW2-1 -: 2]};
		trial         = (RTW+3)'({res_q, 2'b01});
		ge            = rem_sh >= trial;
		diff          = rem_sh - trial;
		res_next      = cmd.step ? RTW'({res_q, ge}) : res_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q   <= RW2'(radicand_used);
			rem_q <= '0;
			res_q <= '0;
			cnt_q <= CNT_W'(RTW - 1);
		end else if (cmd.step) begin
			x_q   <= x_q << 2;
			rem_q <= ge ? diff[RTW:0] : rem_sh[RTW:0];
			res_q <= res_next;
			cnt_q <= cnt_q - 1'b1;
		end
		if (cmd.capture) begin
			root_q <= ROOT_W'(res_next);
		end
	end

	assign sts.last = (cnt_q == '0);
	assign root     = root_q;

endmodule
`default_nettype wire

@@ rtl/isqrt_ctrl.sv @@
// Controller of the integer square root: sequencing and both handshakes.
`default_nettype none
module isqrt_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	input  wire isqrt_pkg::isqrt_sts_t  sts,
	output isqrt_pkg::isqrt_cmd_t       cmd
);
	import isqrt_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_HOLD = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_next;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		cmd        = '0;
		state_next = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = S_RUN;
				end
			end
			S_RUN: begin
				cmd.step = 1'b1;
				if (sts.last) begin
					if (out_free) begin
						cmd.capture = 1'b1;
						state_next  = S_IDLE;
					end else begin
						state_next = S_HOLD;
					end
				end
			end
			S_HOLD: begin
				if (out_free) begin
					cmd.capture = 1'b1;
					state_next  = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.capture) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire
